// ===== rtl/core/image_packet_reassembler_assert.svh =====
// Assertion macros for the image packet reassembler
`ifndef IMAGE_PACKET_REASSEMBLER_ASSERT_SVH
`define IMAGE_PACKET_REASSEMBLER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define IPR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("image_packet_reassembler assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define IPR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("image_packet_reassembler assertion failed");

`endif

// ===== rtl/core/ipr_pkg.sv =====
// Shared types and constants of the image packet reassembler
package ipr_pkg;

  localparam int START_W = 24;
  localparam int SUM_W   = 25;
  localparam int EPOCH_W = 8;

  typedef enum logic [1:0] {
    OP_HANDSHAKE = 2'd0,
    OP_DATA      = 2'd1,
    OP_READ      = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    ST_STARTED     = 4'd0,
    ST_RESTARTED   = 4'd1,
    ST_ZERO_FIELD  = 4'd2,
    ST_SIZE_BIG    = 4'd3,
    ST_PAYLOAD_BIG = 4'd4,
    ST_NO_TRANSFER = 4'd5,
    ST_PAST_END    = 4'd6,
    ST_STORED      = 4'd7,
    ST_CLAMPED     = 4'd8,
    ST_READ        = 4'd9
  } status_t;

endpackage

// ===== rtl/core/ipr_in_if.sv =====
// Input item channel of the image packet reassembler
interface ipr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] image_size;
  logic [7:0]  payload_len;
  logic [15:0] packet_count;
  logic [15:0] seq_number;
  logic [7:0]  byte_offset;
  logic [7:0]  data_byte;
  logic        last_in_packet;
  logic [15:0] read_address;

  modport source (
    output valid, op, image_size, payload_len, packet_count, seq_number,
           byte_offset, data_byte, last_in_packet, read_address,
    input  ready
  );
  modport sink (
    input  valid, op, image_size, payload_len, packet_count, seq_number,
           byte_offset, data_byte, last_in_packet, read_address,
    output ready
  );
endinterface

// ===== rtl/core/ipr_out_if.sv =====
// Result item channel of the image packet reassembler
interface ipr_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [7:0]  read_data;
  logic        image_ready;
  logic [15:0] images_completed;
  logic [15:0] packets_remaining;
  logic        transfer_active;

  modport source (
    output valid, status, read_data, image_ready, images_completed,
           packets_remaining, transfer_active,
    input  ready
  );
  modport sink (
    input  valid, status, read_data, image_ready, images_completed,
           packets_remaining, transfer_active,
    output ready
  );
endinterface

// ===== rtl/core/image_packet_reassembler.sv =====
// Image packet reassembler top level: handshake check, byte store, read back.
// The block takes one item per cycle, back to back, while no clearing pass
// runs and results are taken. One result per item passes a pipeline
// register and an output register, which let it keep accepting while a
// result waits. Every item makes at most one access to the image store, a
// synchronous memory of MAX_IMAGE_BYTES entries whose read data is registered.
// Each entry carries an epoch tag; a handshake starts a new epoch, so stale
// bytes read back as zero. After reset, and after every 255th handshake when
// the epoch wraps, a clearing pass resets the tags; no item is accepted then.
`include "image_packet_reassembler_assert.svh"

module image_packet_reassembler #(
  parameter int MAX_IMAGE_BYTES    = 65536,
  parameter int PACKET_FIELD_BYTES = 253
) (
  input logic clk,
  input logic rst,
  ipr_in_if.sink    item,
  ipr_out_if.source result
);
  import ipr_pkg::*;

  localparam int AW     = $clog2(MAX_IMAGE_BYTES);
  localparam int SIZE_W = $clog2(MAX_IMAGE_BYTES + 1);
  localparam int CMP_W  = (SIZE_W > SUM_W) ? SIZE_W : SUM_W;
  localparam int MEM_W  = EPOCH_W + 8;

  logic [SIZE_W-1:0]  expected_size, expected_size_next;
  logic [7:0]         bytes_per_packet, bytes_per_packet_next;
  logic [15:0]        packets_left, packets_left_next;
  logic [15:0]        done_counter, done_counter_next;
  logic [EPOCH_W-1:0] epoch, epoch_next;
  logic               sweep_active, sweep_start;
  logic [AW-1:0]      sweep_addr;

  logic               p1_valid;
  status_t            p1_status;
  logic               p1_image_ready;
  logic [15:0]        p1_done;
  logic [15:0]        p1_left;
  logic               p1_read;
  logic [EPOCH_W-1:0] p1_epoch;
  logic               p1_move;

  logic               out_valid;
  status_t            out_status;
  logic [7:0]         out_read_data;
  logic               out_image_ready;
  logic [15:0]        out_done;
  logic [15:0]        out_left;

  logic [MEM_W-1:0]   image_mem [MAX_IMAGE_BYTES];
  logic [MEM_W-1:0]   mem_q;
  logic               wr_en, rd_en;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic [MEM_W-1:0]   wr_data;

  logic               accept;
  status_t            status_now;
  logic               image_ready_now;
  logic               read_ok_now;
  logic [START_W-1:0] pkt_start;
  logic [SUM_W-1:0]   byte_addr;
  logic [CMP_W-1:0]   size_ext;

  assign p1_move    = !out_valid || result.ready;
  assign item.ready = !sweep_active && (!p1_valid || p1_move);
  assign accept     = item.valid && item.ready;

  assign pkt_start = START_W'(item.seq_number) * START_W'(bytes_per_packet);
  assign byte_addr = SUM_W'(pkt_start) + SUM_W'(item.byte_offset);
  assign size_ext  = CMP_W'(expected_size);

  always_comb begin
    expected_size_next    = expected_size;
    bytes_per_packet_next = bytes_per_packet;
    packets_left_next     = packets_left;
    done_counter_next     = done_counter;
    epoch_next            = epoch;
    sweep_start           = 1'b0;
    status_now            = ST_READ;
    image_ready_now       = 1'b0;
    read_ok_now           = 1'b0;
    wr_en                 = sweep_active;
    wr_addr               = sweep_addr;
    wr_data               = '0;
    rd_en                 = 1'b0;
    rd_addr               = AW'(item.read_address);
    unique case (item.op)
      OP_HANDSHAKE: begin
        expected_size_next    = '0;
        bytes_per_packet_next = '0;
        packets_left_next     = '0;
        if (epoch == '1) begin
          sweep_start = 1'b1;
          epoch_next  = EPOCH_W'(1);
        end else begin
          epoch_next = epoch + EPOCH_W'(1);
        end
        if (item.image_size == '0 || item.payload_len == '0 ||
            item.packet_count == '0) begin
          status_now = ST_ZERO_FIELD;
        end else if (item.image_size > 32'(MAX_IMAGE_BYTES)) begin
          status_now = ST_SIZE_BIG;
        end else if (item.payload_len > 8'(PACKET_FIELD_BYTES)) begin
          status_now = ST_PAYLOAD_BIG;
        end else begin
          expected_size_next    = item.image_size[SIZE_W-1:0];
          bytes_per_packet_next = item.payload_len;
          packets_left_next     = item.packet_count;
          status_now = (packets_left != '0) ? ST_RESTARTED : ST_STARTED;
        end
      end
      OP_DATA: begin
        if (packets_left == '0) begin
          status_now = ST_NO_TRANSFER;
        end else if (CMP_W'(pkt_start) >= size_ext) begin
          status_now = ST_PAST_END;
        end else begin
          if (item.byte_offset < bytes_per_packet && CMP_W'(byte_addr) < size_ext) begin
            status_now = ST_STORED;
            if (accept) begin
              wr_en   = 1'b1;
              wr_addr = byte_addr[AW-1:0];
              wr_data = {epoch, item.data_byte};
            end
          end else begin
            status_now = ST_CLAMPED;
          end
          if (item.last_in_packet) begin
            packets_left_next = packets_left - 16'd1;
            if (packets_left == 16'd1) begin
              image_ready_now   = 1'b1;
              done_counter_next = done_counter + 16'd1;
            end
          end
        end
      end
      default: begin
        status_now  = ST_READ;
        rd_en       = accept;
        read_ok_now = 32'(item.read_address) < 32'(MAX_IMAGE_BYTES);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_size    <= '0;
      bytes_per_packet <= '0;
      packets_left     <= '0;
      done_counter     <= '0;
      epoch            <= EPOCH_W'(1);
      sweep_active     <= 1'b1;
      sweep_addr       <= '0;
    end else begin
      if (accept) begin
        expected_size    <= expected_size_next;
        bytes_per_packet <= bytes_per_packet_next;
        packets_left     <= packets_left_next;
        done_counter     <= done_counter_next;
        epoch            <= epoch_next;
        if (sweep_start) begin
          sweep_active <= 1'b1;
        end
      end
      if (sweep_active) begin
        if (sweep_addr == AW'(MAX_IMAGE_BYTES - 1)) begin
          sweep_active <= 1'b0;
          sweep_addr   <= '0;
        end else begin
          sweep_addr <= sweep_addr + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      image_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= image_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (accept) begin
      p1_valid <= 1'b1;
    end else if (p1_move) begin
      p1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_status      <= status_now;
      p1_image_ready <= image_ready_now;
      p1_done        <= done_counter_next;
      p1_left        <= packets_left_next;
      p1_read        <= read_ok_now;
      p1_epoch       <= epoch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (p1_move) begin
      out_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_move && p1_valid) begin
      out_status      <= p1_status;
      out_image_ready <= p1_image_ready;
      out_done        <= p1_done;
      out_left        <= p1_left;
      out_read_data   <= (p1_read && mem_q[8 +: EPOCH_W] == p1_epoch) ? mem_q[7:0] : 8'h00;
    end
  end

  assign result.valid             = out_valid;
  assign result.status            = out_status;
  assign result.read_data         = out_read_data;
  assign result.image_ready       = out_image_ready;
  assign result.images_completed  = out_done;
  assign result.packets_remaining = out_left;
  assign result.transfer_active   = (out_left != '0);

  `IPR_ASSERT_NOW(a_no_accept_in_sweep, sweep_active, !item.ready)
  `IPR_ASSERT_NOW(a_stall_blocks_input, p1_valid && out_valid && !result.ready, !item.ready)
  `IPR_ASSERT_NOW(a_ready_ends_transfer, result.valid && result.image_ready,
                  result.packets_remaining == 16'd0 &&
                  (result.status == ST_STORED || result.status == ST_CLAMPED))
  `IPR_ASSERT_NEXT(a_wrap_starts_sweep,
                   accept && item.op == OP_HANDSHAKE && epoch == '1, sweep_active)

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the image packet reassembler: driver, monitor and byte-store predictor
`timescale 1ns / 1ps

module tb_top;
  import ipr_pkg::*;

  localparam int MAX_BYTES   = 65536;
  localparam int FIELD_BYTES = 253;
  localparam int LONG_STALL  = 200;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] image_size;
    logic [7:0]  payload_len;
    logic [15:0] packet_count;
    logic [15:0] seq_number;
    logic [7:0]  byte_offset;
    logic [7:0]  data_byte;
    logic        last_in_packet;
    logic [15:0] read_address;
  } ipr_item_t;

  typedef struct {
    status_t     status;
    logic [7:0]  read_data;
    logic        image_ready;
    logic [15:0] images_completed;
    logic [15:0] packets_remaining;
    logic        transfer_active;
  } ipr_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ipr_in_if  item_ch ();
  ipr_out_if result_ch ();

  image_packet_reassembler #(
    .MAX_IMAGE_BYTES   (MAX_BYTES),
    .PACKET_FIELD_BYTES(FIELD_BYTES)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .result(result_ch)
  );

  always #10 clk = ~clk;

  ipr_item_t   items_to_send[$];
  ipr_result_t results_owed[$];

  logic [16:0] open_size     = '0;
  logic [7:0]  open_payload  = '0;
  logic [15:0] packets_owed  = '0;
  logic [15:0] frames_done   = '0;
  logic [7:0]  image_bytes [MAX_BYTES];
  int unsigned byte_epoch [MAX_BYTES];
  int unsigned store_epoch   = 1;

  int unsigned mismatches        = 0;
  int unsigned items_queued      = 0;
  int unsigned handshakes_queued = 0;
  int unsigned stat_opened       = 0;
  int unsigned stat_stored       = 0;
  int unsigned stat_reads        = 0;
  int unsigned stat_images       = 0;

  bit tx_eager      = 1'b0;
  bit tx_calm       = 1'b0;
  bit rx_calm       = 1'b0;
  bit rx_hold       = 1'b0;
  bit stall_request = 1'b0;
  int unsigned tx_gap = 0;
  int unsigned rx_gap = 0;

  function automatic ipr_result_t reassemble_item(ipr_item_t it);
    ipr_result_t r;
    logic [31:0] start_addr;
    logic [31:0] addr;
    logic        was_open;
    r.status      = ST_READ;
    r.read_data   = '0;
    r.image_ready = 1'b0;
    case (it.op)
      OP_HANDSHAKE: begin
        was_open     = packets_owed != 0;
        store_epoch++;
        open_size    = '0;
        open_payload = '0;
        packets_owed = '0;
        if (it.image_size == 0 || it.payload_len == 0 || it.packet_count == 0) begin
          r.status = ST_ZERO_FIELD;
        end else if (it.image_size > MAX_BYTES) begin
          r.status = ST_SIZE_BIG;
        end else if (it.payload_len > FIELD_BYTES) begin
          r.status = ST_PAYLOAD_BIG;
        end else begin
          open_size    = it.image_size[16:0];
          open_payload = it.payload_len;
          packets_owed = it.packet_count;
          r.status     = was_open ? ST_RESTARTED : ST_STARTED;
          stat_opened++;
        end
      end
      OP_DATA: begin
        if (packets_owed == 0) begin
          r.status = ST_NO_TRANSFER;
        end else begin
          start_addr = it.seq_number * open_payload;
          if (start_addr >= open_size) begin
            r.status = ST_PAST_END;
          end else begin
            addr = start_addr + it.byte_offset;
            if (it.byte_offset < open_payload && addr < open_size) begin
              image_bytes[addr] = it.data_byte;
              byte_epoch[addr]  = store_epoch;
              r.status = ST_STORED;
              stat_stored++;
            end else begin
              r.status = ST_CLAMPED;
            end
            if (it.last_in_packet) begin
              packets_owed--;
              if (packets_owed == 0) begin
                r.image_ready = 1'b1;
                frames_done++;
                stat_images++;
              end
            end
          end
        end
      end
      default: begin
        if (byte_epoch[it.read_address] == store_epoch) begin
          r.read_data = image_bytes[it.read_address];
        end
        stat_reads++;
      end
    endcase
    r.images_completed  = frames_done;
    r.packets_remaining = packets_owed;
    r.transfer_active   = packets_owed != 0;
    return r;
  endfunction

  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : driver
    bit fire;
    ipr_item_t nxt;
    if (rst) begin
      item_ch.valid <= 1'b0;
      tx_gap = 0;
    end else begin
      fire = item_ch.valid && item_ch.ready;
      if (fire) begin
        results_owed.push_back(reassemble_item(items_to_send.pop_front()));
        tx_gap = tx_eager ? 0 : pick_gap(tx_calm);
      end
      if (fire || !item_ch.valid) begin
        if (tx_gap > 0) begin
          item_ch.valid <= 1'b0;
          tx_gap--;
        end else if (items_to_send.size() != 0) begin
          nxt = items_to_send[0];
          item_ch.op             <= nxt.op;
          item_ch.image_size     <= nxt.image_size;
          item_ch.payload_len    <= nxt.payload_len;
          item_ch.packet_count   <= nxt.packet_count;
          item_ch.seq_number     <= nxt.seq_number;
          item_ch.byte_offset    <= nxt.byte_offset;
          item_ch.data_byte      <= nxt.data_byte;
          item_ch.last_in_packet <= nxt.last_in_packet;
          item_ch.read_address   <= nxt.read_address;
          item_ch.valid          <= 1'b1;
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
      if ($urandom_range(0, 127) == 0) tx_calm = !tx_calm;
    end
  end

  always @(posedge clk) begin : monitor
    ipr_result_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (results_owed.size() == 0) begin
          $error("result beat with no result owed");
          mismatches++;
        end else begin
          want = results_owed.pop_front();
          check_field("status", want.status, result_ch.status);
          check_field("read_data", want.read_data, result_ch.read_data);
          check_field("image_ready", want.image_ready, result_ch.image_ready);
          check_field("images_completed", want.images_completed, result_ch.images_completed);
          check_field("packets_remaining", want.packets_remaining,
                      result_ch.packets_remaining);
          check_field("transfer_active", want.transfer_active, result_ch.transfer_active);
        end
      end
      if (rx_hold) begin
        result_ch.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        result_ch.ready <= 1'b0;
        rx_gap--;
      end else begin
        result_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) rx_gap = pick_gap(rx_calm);
      end
      if ($urandom_range(0, 127) == 0) rx_calm = !rx_calm;
    end
  end

  initial begin : rx_long_stall
    wait (stall_request);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (LONG_STALL) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin : watchdog
    #20_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  task automatic queue_item(ipr_item_t it);
    items_to_send.push_back(it);
    items_queued++;
    if (it.op == OP_HANDSHAKE) handshakes_queued++;
  endtask

  function automatic ipr_item_t noise_item();
    ipr_item_t it;
    it.op             = 2'($urandom_range(0, 3));
    it.image_size     = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 70000) : $urandom;
    it.payload_len    = 8'($urandom);
    it.packet_count   = 16'($urandom);
    it.seq_number     = 16'($urandom);
    it.byte_offset    = 8'($urandom_range(0, 252));
    it.data_byte      = 8'($urandom);
    it.last_in_packet = 1'($urandom);
    it.read_address   = 16'($urandom);
    return it;
  endfunction

  task automatic send_handshake(int unsigned img, int unsigned payload, int unsigned count);
    ipr_item_t it;
    it = noise_item();
    it.op           = OP_HANDSHAKE;
    it.image_size   = img;
    it.payload_len  = 8'(payload);
    it.packet_count = 16'(count);
    queue_item(it);
  endtask

  task automatic send_byte(int unsigned seq, int unsigned off, int unsigned val, bit last);
    ipr_item_t it;
    it = noise_item();
    it.op             = OP_DATA;
    it.seq_number     = 16'(seq);
    it.byte_offset    = 8'(off);
    it.data_byte      = 8'(val);
    it.last_in_packet = last;
    queue_item(it);
  endtask

  task automatic send_read(int unsigned addr, bit alt);
    ipr_item_t it;
    it = noise_item();
    it.op           = alt ? OP_UNUSED : OP_READ;
    it.read_address = 16'(addr);
    queue_item(it);
  endtask

  task automatic send_small_transfer();
    int unsigned p, c, img, len, k, j, tmp;
    int unsigned order[$];
    p   = $urandom_range(1, 8);
    c   = $urandom_range(1, 5);
    img = p * c - $urandom_range(0, p - 1);
    send_handshake(img, p, c);
    for (k = 0; k < c; k++) order.push_back(k);
    for (k = c - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    foreach (order[i]) begin
      len = (order[i] == c - 1) ? img - order[i] * p : p;
      for (k = 0; k < len; k++) send_byte(order[i], k, $urandom_range(0, 255), k == len - 1);
      if ($urandom_range(0, 7) == 0)
        send_byte(order[i], $urandom_range(p, 252), $urandom_range(0, 255),
                  $urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0)
        send_byte($urandom_range(c, 65535), $urandom_range(0, 252), $urandom_range(0, 255),
                  $urandom_range(0, 1));
      if ($urandom_range(0, 5) == 0)
        send_read($urandom_range(0, img + 2), $urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) break;
    end
    repeat (3) send_read($urandom_range(0, img + 2), $urandom_range(0, 3) == 0);
  endtask

  task automatic send_large_transfer();
    int unsigned img, p, seq, off;
    img = ($urandom_range(0, 3) == 0) ? MAX_BYTES : $urandom_range(1, MAX_BYTES);
    p   = ($urandom_range(0, 3) == 0) ? FIELD_BYTES : $urandom_range(1, FIELD_BYTES);
    send_handshake(img, p, $urandom_range(1, 65535));
    repeat ($urandom_range(3, 8)) begin
      seq = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, (img - 1) / p);
      off = $urandom_range(0, 252);
      send_byte(seq, off, $urandom_range(0, 255), $urandom_range(0, 3) == 0);
      if (seq * p + off < MAX_BYTES && $urandom_range(0, 1)) send_read(seq * p + off, 1'b0);
    end
  endtask

  task automatic drain();
    while (items_to_send.size() != 0 || results_owed.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned random_floor, k;
    ipr_item_t it;
    item_ch.valid          = 1'b0;
    item_ch.op             = OP_HANDSHAKE;
    item_ch.image_size     = '0;
    item_ch.payload_len    = '0;
    item_ch.packet_count   = '0;
    item_ch.seq_number     = '0;
    item_ch.byte_offset    = '0;
    item_ch.data_byte      = '0;
    item_ch.last_in_packet = 1'b0;
    item_ch.read_address   = '0;
    result_ch.ready        = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_read(0, 1'b0);
    send_byte(0, 0, 8'h11, 1'b1);
    send_handshake(0, 4, 1);
    send_handshake(10, 0, 1);
    send_handshake(10, 4, 0);
    send_handshake(MAX_BYTES + 1, 4, 1);
    send_handshake(32'hFFFF_FFFF, 255, 16'hFFFF);
    send_handshake(100, FIELD_BYTES + 1, 1);
    send_handshake(MAX_BYTES, FIELD_BYTES, 3);
    send_byte(259, 0, 8'h00, 1'b0);
    send_byte(259, 8, 8'hFF, 1'b0);
    send_byte(259, 9, 8'h77, 1'b1);
    send_byte(260, 0, 8'h66, 1'b1);
    send_byte(16'hFFFF, 252, 8'h55, 1'b1);
    send_byte(0, 252, 8'hA5, 1'b1);
    send_read(MAX_BYTES - 1, 1'b0);
    send_read(252, 1'b1);
    send_handshake(5, 2, 3);
    send_read(252, 1'b0);
    send_byte(0, 2, 8'h99, 1'b0);
    send_byte(2, 0, 8'h5A, 1'b1);
    send_byte(1, 1, 8'hC3, 1'b1);
    send_byte(0, 0, 8'h3C, 1'b1);
    send_byte(0, 0, 8'h01, 1'b0);
    send_read(4, 1'b0);
    drain();

    tx_eager = 1'b1;
    stall_request = 1'b1;
    send_small_transfer();
    send_small_transfer();
    send_small_transfer();
    drain();
    tx_eager = 1'b0;

    random_floor = items_queued;
    while (items_queued < random_floor + 40) begin
      k = $urandom_range(0, 99);
      if (k < 65) begin
        send_small_transfer();
      end else if (k < 75) begin
        send_large_transfer();
      end else begin
        repeat ($urandom_range(1, 4)) queue_item(noise_item());
      end
    end
    drain();

    while (handshakes_queued < 280) begin
      if (handshakes_queued % 16 == 0) begin
        send_handshake(8, 8, 1);
        k = $urandom_range(0, 7);
        send_byte(0, k, $urandom_range(0, 255), 1'b0);
        send_read(k, 1'b0);
        send_read($urandom_range(0, 7), 1'b1);
      end else begin
        it = noise_item();
        it.op = OP_HANDSHAKE;
        queue_item(it);
      end
    end
    for (k = 0; k < 8; k++) send_read(k, 1'b0);
    drain();

    repeat (16) @(posedge clk);
    $display("tb_top: %0d items, %0d handshakes (%0d opened a transfer), %0d reads",
             items_queued, handshakes_queued, stat_opened, stat_reads);
    $display("tb_top: %0d bytes stored, %0d images completed, %0d mismatches",
             stat_stored, stat_images, mismatches);
    if (mismatches == 0 && results_owed.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
